// ===== rtl/bq_pkg.sv =====
`default_nettype none

package bq_pkg;

   localparam int DEFAULT_CHANNELS = 4;

   localparam int CHAN_W    = 2;
   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 16;
   localparam int CSR_IDX_W = 3;
   localparam int DELAY_W   = 36;
   localparam int PROD_W    = 2 * COEF_W;
   localparam int SUM_W     = 38;
   localparam int FRAC_W    = 14;
   localparam int QUOT_W    = SUM_W - FRAC_W;

   localparam logic signed [COEF_W-1:0] COEF_B0_RESET = 16'sd16384;

   localparam logic signed [SUM_W-1:0] ROUND_HALF = 38'sd8192;
   localparam logic signed [SUM_W-1:0] DELAY_MAX  = 38'sd34359738367;
   localparam logic signed [SUM_W-1:0] DELAY_MIN  = -38'sd34359738368;
   localparam logic signed [QUOT_W-1:0] OUT_MAX   = 24'sd32767;
   localparam logic signed [QUOT_W-1:0] OUT_MIN   = -24'sd32768;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_B0 = 3'd0,
      CSR_B1 = 3'd1,
      CSR_B2 = 3'd2,
      CSR_A1 = 3'd3,
      CSR_A2 = 3'd4
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_B0,
      ST_Y,
      ST_A1,
      ST_B2,
      ST_A2,
      ST_D2,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      MUL_B0X,
      MUL_B1X,
      MUL_A1Y,
      MUL_B2X,
      MUL_A2Y
   } mul_sel_type;

   typedef enum logic [1:0] {
      ADD_D1R,
      ADD_D2,
      ADD_ACC,
      ADD_ZERO
   } add_sel_type;

   typedef struct packed {
      logic        req_ready;
      mul_sel_type mul_sel;
      add_sel_type add_sel;
      logic        sub_prod;
      logic        acc_en;
      logic        y_load;
      logic        d1_write;
      logic        d2_write;
      logic        out_load;
   } seq_ctl_type;

   function automatic logic signed [DELAY_W-1:0] sat_delay(input logic signed [SUM_W-1:0] v);
      logic signed [DELAY_W-1:0] r;
      if (v > DELAY_MAX) begin
         r = DELAY_MAX[DELAY_W-1:0];
      end else if (v < DELAY_MIN) begin
         r = DELAY_MIN[DELAY_W-1:0];
      end else begin
         r = v[DELAY_W-1:0];
      end
      return r;
   endfunction

   // floor by 2^14 is an arithmetic shift; rounding bias already added
   function automatic logic signed [SAMPLE_W-1:0] round_sat_out(
      input logic signed [SUM_W-1:0] v);
      logic signed [QUOT_W-1:0] q;
      logic signed [SAMPLE_W-1:0] r;
      q = v[SUM_W-1:FRAC_W];
      if (q > OUT_MAX) begin
         r = OUT_MAX[SAMPLE_W-1:0];
      end else if (q < OUT_MIN) begin
         r = OUT_MIN[SAMPLE_W-1:0];
      end else begin
         r = q[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/biquad_lowpass_df2t.sv =====
// Biquad IIR filter, direct form II transposed, time-shared over CHANNELS
// channels with five common Q2.14 coefficients. A request is taken when the
// block is idle and its result is loaded into the output register at the
// end of the sequence, once the output register is free. The block takes no
// new request until then. The single 16x16 multiplier forms the five
// products b0*x, b1*x, a1*y, b2*x and a2*y one per cycle, and the 38-bit
// adder works on the registered product. A waiting result does not block
// the next request. Any coefficient write clears the delay words of all
// channels; write coefficients only while the block is idle. A request for
// a channel at or above CHANNELS returns zero and writes no delay word.

`default_nettype none

module biquad_lowpass_df2t import bq_pkg::*; #(
   parameter int CHANNELS = DEFAULT_CHANNELS
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire logic [CHAN_W-1:0]           req_channel,
   input  wire logic signed [SAMPLE_W-1:0]  req_sample_in,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic [CHAN_W-1:0]                rsp_channel_out,
   output logic signed [SAMPLE_W-1:0]       rsp_sample_out,
   input  wire                              csr_we,
   input  wire logic [CSR_IDX_W-1:0]        csr_index,
   input  wire logic [COEF_W-1:0]           csr_wdata
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   seq_ctl_type ctl;
   logic        out_free;
   logic        req_fire;

   logic signed [COEF_W-1:0] b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   logic signed [DELAY_W-1:0] delay_one_ff [CHANNELS];
   logic signed [DELAY_W-1:0] delay_two_ff [CHANNELS];

   logic [CHAN_W-1:0]          ch_ff;
   logic [IDX_W-1:0]           idx_ff;
   logic                       ok_ff;
   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [SAMPLE_W-1:0] y_ff;
   logic                       rsp_valid_ff;
   logic [CHAN_W-1:0]          rsp_channel_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;

   logic [IDX_W+CHAN_W-1:0]    chan_ext;
   logic signed [COEF_W-1:0]   mul_a;
   logic signed [SAMPLE_W-1:0] mul_b;
   logic signed [SUM_W-1:0]    sum;
   logic signed [DELAY_W-1:0]  d1_rd;
   logic signed [DELAY_W-1:0]  d2_rd;
   logic                       coef_hit;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = ctl.req_ready;
   assign req_fire  = req_valid && ctl.req_ready;
   assign chan_ext  = (IDX_W + CHAN_W)'(req_channel);
   assign d1_rd     = delay_one_ff[idx_ff];
   assign d2_rd     = delay_two_ff[idx_ff];

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_channel_out = rsp_channel_ff;
   assign rsp_sample_out  = rsp_sample_ff;

   bq_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .ctl       (ctl)
   );

   always_comb begin
      mul_a = b0_ff;
      mul_b = x_ff;
      case (ctl.mul_sel)
         MUL_B0X: begin mul_a = b0_ff; mul_b = x_ff; end
         MUL_B1X: begin mul_a = b1_ff; mul_b = x_ff; end
         MUL_A1Y: begin mul_a = a1_ff; mul_b = y_ff; end
         MUL_B2X: begin mul_a = b2_ff; mul_b = x_ff; end
         MUL_A2Y: begin mul_a = a2_ff; mul_b = y_ff; end
         default: begin mul_a = b0_ff; mul_b = x_ff; end
      endcase
   end

   bq_mac u_mac (
      .clock (clock),
      .ctl   (ctl),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .d1_rd (d1_rd),
      .d2_rd (d2_rd),
      .sum   (sum)
   );

   always_comb begin
      coef_hit = 1'b0;
      unique case (csr_index)
         CSR_B0, CSR_B1, CSR_B2, CSR_A1, CSR_A2: coef_hit = csr_we;
         default:                                coef_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff <= COEF_B0_RESET;
         b1_ff <= '0;
         b2_ff <= '0;
         a1_ff <= '0;
         a2_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_B0:  b0_ff <= csr_wdata;
            CSR_B1:  b1_ff <= csr_wdata;
            CSR_B2:  b2_ff <= csr_wdata;
            CSR_A1:  a1_ff <= csr_wdata;
            CSR_A2:  a2_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || coef_hit) begin
         for (int i = 0; i < CHANNELS; i++) begin
            delay_one_ff[i] <= '0;
            delay_two_ff[i] <= '0;
         end
      end else begin
         if (ctl.d1_write && ok_ff) begin
            delay_one_ff[idx_ff] <= sat_delay(sum);
         end
         if (ctl.d2_write && ok_ff) begin
            delay_two_ff[idx_ff] <= sat_delay(sum);
         end
      end
   end

   // request payload and working registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         ch_ff  <= req_channel;
         idx_ff <= chan_ext[IDX_W-1:0];
         ok_ff  <= (32'(req_channel) < CHANNELS);
         x_ff   <= req_sample_in;
      end
      if (ctl.y_load) begin
         y_ff <= round_sat_out(sum);
      end
      if (ctl.out_load) begin
         rsp_channel_ff <= ch_ff;
         rsp_sample_ff  <= ok_ff ? y_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bq_mac.sv =====
`default_nettype none

module bq_mac import bq_pkg::*; (
   input  wire                              clock,
   input  wire seq_ctl_type                 ctl,
   input  wire logic signed [COEF_W-1:0]    mul_a,
   input  wire logic signed [SAMPLE_W-1:0]  mul_b,
   input  wire logic signed [DELAY_W-1:0]   d1_rd,
   input  wire logic signed [DELAY_W-1:0]   d2_rd,
   output logic signed [SUM_W-1:0]          sum
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [SUM_W-1:0]  acc_ff;
   logic signed [SUM_W-1:0]  addend;
   logic signed [SUM_W-1:0]  prod_ext;

   assign prod_in  = mul_a * mul_b;
   assign prod_ext = SUM_W'(prod_ff);

   always_comb begin
      addend = '0;
      case (ctl.add_sel)
         ADD_D1R:  addend = SUM_W'(d1_rd) + ROUND_HALF;
         ADD_D2:   addend = SUM_W'(d2_rd);
         ADD_ACC:  addend = acc_ff;
         ADD_ZERO: addend = '0;
         default:  addend = '0;
      endcase
      sum = ctl.sub_prod ? (addend - prod_ext) : (addend + prod_ext);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (ctl.acc_en) begin
         acc_ff <= sum;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bq_seq.sv =====
`default_nettype none

module bq_seq import bq_pkg::*; (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   input  wire          out_free,
   output seq_ctl_type  ctl
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ctl          = '0;
      ctl.mul_sel  = MUL_B0X;
      ctl.add_sel  = ADD_ZERO;
      unique case (state_ff)
         ST_IDLE: begin
            ctl.req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_B0;
            end
         end
         ST_B0: begin
            ctl.mul_sel = MUL_B0X;
            state_in    = ST_Y;
         end
         ST_Y: begin
            // b0*x + d1 + half, then round and clamp into y
            ctl.mul_sel = MUL_B1X;
            ctl.add_sel = ADD_D1R;
            ctl.y_load  = 1'b1;
            state_in    = ST_A1;
         end
         ST_A1: begin
            ctl.mul_sel = MUL_A1Y;
            ctl.add_sel = ADD_D2;
            ctl.acc_en  = 1'b1;
            state_in    = ST_B2;
         end
         ST_B2: begin
            ctl.mul_sel  = MUL_B2X;
            ctl.add_sel  = ADD_ACC;
            ctl.sub_prod = 1'b1;
            ctl.d1_write = 1'b1;
            state_in     = ST_A2;
         end
         ST_A2: begin
            ctl.mul_sel = MUL_A2Y;
            ctl.add_sel = ADD_ZERO;
            ctl.acc_en  = 1'b1;
            state_in    = ST_D2;
         end
         ST_D2: begin
            ctl.add_sel  = ADD_ACC;
            ctl.sub_prod = 1'b1;
            ctl.d2_write = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               ctl.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/bq_checker.sv =====
`default_nettype none

module bq_checker import bq_pkg::*; (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_valid,
   input wire                              req_ready,
   input wire logic [CHAN_W-1:0]           req_channel,
   input wire logic signed [SAMPLE_W-1:0]  req_sample_in,
   input wire                              rsp_valid,
   input wire                              rsp_ready,
   input wire logic [CHAN_W-1:0]           rsp_channel_out,
   input wire logic signed [SAMPLE_W-1:0]  rsp_sample_out,
   input wire                              csr_we,
   input wire logic [CSR_IDX_W-1:0]        csr_index,
   input wire logic [COEF_W-1:0]           csr_wdata
);

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_channel_out)
         && $stable(rsp_sample_out))
      else $error("result changed while stalled");

   // busy right after a request is taken
   a_busy_next: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after request");

   // the shared multiplier keeps the block busy through the whole sequence
   a_busy_seq: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##6 !req_ready)
      else $error("sequence ended early");

   // a new result only appears at the end of a busy stretch
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while idle");

endmodule

bind biquad_lowpass_df2t bq_checker u_bq_checker (.*);

`default_nettype wire
